FILE: design/page_table_walker_16k_core_macros.svh
// Assertion macros shared by the walker modules.
`ifndef PAGE_TABLE_WALKER_16K_CORE_MACROS_SVH
`define PAGE_TABLE_WALKER_16K_CORE_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define PTW_ASSERT_IMP(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define PTW_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: design/ptw16k_pkg.sv
// Package: constants, codes and types of the 16 KiB granule walker.
package ptw16k_pkg;
	localparam logic [63:0] ADDR_MASK = 64'h0000_FFFF_FFFF_C000;
	localparam int PAGE_SHIFT = 14;
	localparam logic [3:0] FSC_TRANS = 4'h4;
	localparam logic [3:0] FSC_AF = 4'h8;
	localparam logic [3:0] FSC_PERM = 4'hC;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_PHYS = 3'd1, ST_GRANULE = 3'd2, ST_ASIZE = 3'd3,
		ST_TRANS = 3'd4, ST_AF = 3'd5, ST_PERM = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		REG_MMU = 3'd0, REG_TCR = 3'd1, REG_TTB0 = 3'd2, REG_TTB1 = 3'd3,
		REG_USER = 3'd4, REG_MEMSZ = 3'd5
	} reg_idx_t;

	localparam logic [1:0] ACC_WRITE = 2'd1;
	localparam logic [1:0] ACC_EXEC = 2'd2;

	// One word from front end to back end.
	typedef struct packed {
		logic        command;
		logic [63:0] va;
		logic [1:0]  access;
		logic [63:0] desc;
		logic        failed;
	} cmd_t;

	// One result word.
	typedef struct packed {
		logic        kind;
		logic [47:0] addr;
		status_t     status;
		logic [1:0]  level;
		logic [3:0]  code;
		logic [47:0] daddr;
		logic [63:0] desc;
		logic        is_write;
		logic        is_exec;
		logic [63:0] va;
	} res_t;

	// Start level from the region size (15..48 bits).
	function automatic logic [1:0] start_level(input logic [6:0] va_bits);
		logic [1:0] lv;
		if (va_bits <= 7'd25) lv = 2'd3;
		else if (va_bits <= 7'd36) lv = 2'd2;
		else if (va_bits <= 7'd47) lv = 2'd1;
		else lv = 2'd0;
		return lv;
	endfunction
endpackage

FILE: design/ptw16k_front.sv
// Front end: take command words and hold them in a two-entry queue.
module ptw16k_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ptw16k_pkg::cmd_t  in_cmd,
	output logic              q_valid,
	input  logic              q_ready,
	output ptw16k_pkg::cmd_t  q_cmd
);
	ptw16k_pkg::cmd_t ent_q [2];
	logic             rd_q, wr_q;
	logic [1:0]       cnt_q;
	logic             push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = ent_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= in_cmd;
	end

	`include "page_table_walker_16k_core_macros.svh"
	`PTW_ASSERT_IMP(a_no_over, clk, arst_n, cnt_q == 2'd2, !in_ready)
	`PTW_ASSERT_NEXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
	`PTW_ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, cnt_q != 2'd3)
endmodule

FILE: design/ptw16k_back.sv
// Back end: walk state, one decision per word, registered result.
module ptw16k_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  ptw16k_pkg::cmd_t  q_cmd,
	input  logic              mmu_enable,
	input  logic [63:0]       tcr,
	input  logic [63:0]       ttb0,
	input  logic [63:0]       ttb1,
	input  logic              user_mode,
	input  logic [48:0]       memory_size,
	output logic              out_valid,
	input  logic              out_ready,
	output ptw16k_pkg::res_t  out_res
);
	logic        busy_q;
	logic [1:0]  level_q, first_q, acc_q;
	logic [47:0] base_q, last_q;
	logic [63:0] pend_q;
	logic [5:0]  region_q;
	ptw16k_pkg::res_t res_q;
	logic        ov_q;

	// Combinational decision.
	logic        emit, go_busy, go_idle, is_read;
	logic [1:0]  n_level, n_first, n_acc;
	logic [47:0] n_base;
	logic [63:0] n_pend;
	logic [5:0]  n_region;
	ptw16k_pkg::res_t r;

	logic        upper;
	logic [5:0]  txsz;
	logic [6:0]  va_bits;
	logic [63:0] hmask, pa, omask;
	logic [5:0]  shift;
	logic [3:0]  ibits;
	logic [10:0] index;
	logic [1:0]  rl;
	logic [63:0] ra;
	logic [47:0] rb;
	logic [5:0]  rr;
	logic [1:0]  rf;
	logic        step;

	assign step = q_valid && (!ov_q || out_ready);
	assign q_ready = !ov_q || out_ready;

	always_comb begin
		emit = 1'b0; go_busy = 1'b0; go_idle = 1'b0; is_read = 1'b0;
		n_level = level_q; n_first = first_q; n_acc = acc_q; n_base = base_q;
		n_pend = pend_q; n_region = region_q;
		r = '0;
		upper = q_cmd.va[63];
		txsz = upper ? tcr[21:16] : tcr[5:0];
		va_bits = 7'd64 - {1'b0, txsz};
		hmask = ~((64'd1 << va_bits[5:0]) - 64'd1);
		if (va_bits[6]) hmask = '0;
		omask = '0; pa = '0;
		if (!q_cmd.command) begin
			if (!busy_q) begin
				emit = 1'b1;
				r.kind = 1'b1;
				r.is_write = (q_cmd.access == ptw16k_pkg::ACC_WRITE);
				r.is_exec = (q_cmd.access == ptw16k_pkg::ACC_EXEC);
				r.va = q_cmd.va;
				if (!mmu_enable) begin
					if ({15'd0, q_cmd.va[48:0]} != q_cmd.va ||
							q_cmd.va[48:0] >= memory_size)
						r.status = ptw16k_pkg::ST_PHYS;
					else begin
						r = '0; r.kind = 1'b1; r.addr = q_cmd.va[47:0];
					end
				end else if ((!upper && tcr[15:14] != 2'd2) ||
						(upper && tcr[31:30] != 2'd1))
					r.status = ptw16k_pkg::ST_GRANULE;
				else if (va_bits < 7'd15 || va_bits > 7'd48)
					r.status = ptw16k_pkg::ST_ASIZE;
				else if (upper ? ((q_cmd.va & hmask) != hmask)
						: ((q_cmd.va & hmask) != 64'd0))
					r.status = ptw16k_pkg::ST_ASIZE;
				else begin
					go_busy = 1'b1; is_read = 1'b1;
					n_pend = q_cmd.va; n_acc = q_cmd.access;
					n_region = va_bits[5:0];
					n_first = ptw16k_pkg::start_level(va_bits);
					n_level = n_first;
					n_base = upper ? ttb1[47:0] & ptw16k_pkg::ADDR_MASK[47:0]
						: ttb0[47:0] & ptw16k_pkg::ADDR_MASK[47:0];
				end
			end
		end else if (busy_q) begin
			emit = 1'b1;
			r.kind = 1'b1; r.level = level_q; r.daddr = last_q;
			r.desc = q_cmd.desc; r.va = pend_q;
			r.is_write = (acc_q == ptw16k_pkg::ACC_WRITE);
			r.is_exec = (acc_q == ptw16k_pkg::ACC_EXEC);
			go_idle = 1'b1;
			omask = (64'd1 << (6'd14 + 6'd11 * {4'd0, 2'd3 - level_q})) - 64'd1;
			pa = (q_cmd.desc & ptw16k_pkg::ADDR_MASK & ~omask) | (pend_q & omask);
			if (q_cmd.failed) begin
				r.status = ptw16k_pkg::ST_PHYS;
				r.code = ptw16k_pkg::FSC_TRANS + {2'd0, level_q}; r.desc = '0;
			end else if (!q_cmd.desc[0]) begin
				r.status = ptw16k_pkg::ST_TRANS;
				r.code = ptw16k_pkg::FSC_TRANS + {2'd0, level_q};
			end else if (level_q != 2'd3 && q_cmd.desc[1]) begin
				go_idle = 1'b0; is_read = 1'b1;
				n_base = q_cmd.desc[47:0] & ptw16k_pkg::ADDR_MASK[47:0];
				n_level = level_q + 2'd1;
			end else if ((level_q == 2'd0 || level_q == 2'd3) && !q_cmd.desc[1]) begin
				r.status = ptw16k_pkg::ST_TRANS;
				r.code = ptw16k_pkg::FSC_TRANS + {2'd0, level_q};
			end else if (!q_cmd.desc[10]) begin
				r.status = ptw16k_pkg::ST_AF;
				r.code = ptw16k_pkg::FSC_AF + {2'd0, level_q};
			end else if ((acc_q == ptw16k_pkg::ACC_WRITE && q_cmd.desc[7]) ||
					(acc_q == ptw16k_pkg::ACC_EXEC &&
					(user_mode ? q_cmd.desc[54] : q_cmd.desc[53]))) begin
				r.status = ptw16k_pkg::ST_PERM;
				r.code = ptw16k_pkg::FSC_PERM + {2'd0, level_q};
			end else if ({15'd0, pa[48:0]} != pa || pa[48:0] >= memory_size) begin
				r.status = ptw16k_pkg::ST_PHYS;
				r.code = ptw16k_pkg::FSC_TRANS + {2'd0, level_q};
			end else begin
				r = '0; r.kind = 1'b1; r.addr = pa[47:0];
			end
		end
		// Descriptor read address for the new level.
		rl = n_level; ra = n_pend; rb = n_base; rr = n_region; rf = n_first;
		shift = 6'd14 + 6'd11 * {4'd0, 2'd3 - rl};
		ibits = 4'd11;
		if (rl == rf && rr > shift && (rr - shift) < 6'd11) ibits = 4'(rr - shift);
		index = 11'(ra >> shift) & 11'((12'd1 << ibits) - 12'd1);
		if (is_read) begin
			r = '0;
			r.addr = rb + {34'd0, index, 3'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; level_q <= '0; first_q <= '0; acc_q <= '0;
			base_q <= '0; pend_q <= '0; region_q <= '0; last_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (out_ready) ov_q <= 1'b0;
			if (step) begin
				if (emit) ov_q <= 1'b1;
				if (go_busy) busy_q <= 1'b1;
				if (go_idle) busy_q <= 1'b0;
				level_q <= n_level; first_q <= n_first; acc_q <= n_acc;
				base_q <= n_base; pend_q <= n_pend; region_q <= n_region;
				if (is_read) last_q <= r.addr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) res_q <= r;
	end

	assign out_valid = ov_q;
	assign out_res = res_q;

	`include "page_table_walker_16k_core_macros.svh"
	`PTW_ASSERT_NEXT(a_hold, clk, arst_n, ov_q && !out_ready, ov_q)
	`PTW_ASSERT_IMP(a_read_busy, clk, arst_n, step && is_read, emit)
	`PTW_ASSERT_NEXT(a_busy_read, clk, arst_n, step && go_busy, busy_q && !res_q.kind)
endmodule

FILE: design/page_table_walker_16k_core.sv
// Top level: 16 KiB granule stage-1 walker with config registers.
// A command word taken into the two-word input queue is decided in the back end, whose
// result word is registered and held until out_ready; each word is one decision there.
// Throughput: one command word per cycle while a result held by out_ready does not stall.
// Reset (arst_n low): config registers clear, walker goes idle, queue and output empty.
module page_table_walker_16k_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [63:0] vaddr,
	input  logic [1:0]  access_kind,
	input  logic [63:0] read_data,
	input  logic        read_failed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [47:0] out_address,
	output logic [2:0]  status,
	output logic [1:0]  fault_level,
	output logic [3:0]  fault_code,
	output logic [47:0] fault_descriptor_address,
	output logic [63:0] fault_descriptor,
	output logic        fault_is_write,
	output logic        fault_is_execute,
	output logic [63:0] fault_virtual_address
);
	// Config registers, written whenever a word arrives.
	logic        mmu_q, user_q;
	logic [63:0] tcr_q, ttb0_q, ttb1_q;
	logic [48:0] msz_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mmu_q <= 1'b0; user_q <= 1'b0; tcr_q <= '0; ttb0_q <= '0;
			ttb1_q <= '0; msz_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ptw16k_pkg::REG_MMU: mmu_q <= cfg_data[0];
				ptw16k_pkg::REG_TCR: tcr_q <= cfg_data;
				ptw16k_pkg::REG_TTB0: ttb0_q <= cfg_data;
				ptw16k_pkg::REG_TTB1: ttb1_q <= cfg_data;
				ptw16k_pkg::REG_USER: user_q <= cfg_data[0];
				ptw16k_pkg::REG_MEMSZ: msz_q <= cfg_data[48:0];
				default: ;
			endcase
		end
	end

	ptw16k_pkg::cmd_t in_cmd, q_cmd;
	ptw16k_pkg::res_t res;
	logic q_valid, q_ready;

	// Pack the input word.
	assign in_cmd = '{command: command, va: vaddr, access: access_kind,
		desc: read_data, failed: read_failed};

	ptw16k_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	ptw16k_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_cmd(q_cmd), .mmu_enable(mmu_q), .tcr(tcr_q), .ttb0(ttb0_q),
		.ttb1(ttb1_q), .user_mode(user_q), .memory_size(msz_q),
		.out_valid(out_valid), .out_ready(out_ready), .out_res(res)
	);

	// Unpack the result word.
	assign result_kind = res.kind;
	assign out_address = res.addr;
	assign status = res.status;
	assign fault_level = res.level;
	assign fault_code = res.code;
	assign fault_descriptor_address = res.daddr;
	assign fault_descriptor = res.desc;
	assign fault_is_write = res.is_write;
	assign fault_is_execute = res.is_exec;
	assign fault_virtual_address = res.va;
endmodule
